FILE: design/edf_pkg.sv
// package for the edf tick scheduler: sizes, register indexes and cell link types
// no dependencies
package edf_pkg;

  localparam int unsigned TASKS     = 4;
  localparam int unsigned IDX_W     = 2;
  localparam int unsigned VAL_W     = 8;
  localparam int unsigned REG_IDX_W = 3;

  // register index bases
  localparam logic [REG_IDX_W-1:0] REG_DEADLINE_BASE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COST_BASE     = 3'd4;

  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

  // data handed from one cell to the next within a tick
  typedef struct packed {
    logic             miss;
    logic [IDX_W-1:0] miss_idx;
    logic             found;
    logic [IDX_W-1:0] best_idx;
    logic [VAL_W-1:0] best_left;
  } link_t;

  // per tick decision broadcast to every cell
  typedef struct packed {
    logic             accept;
    logic             start;
    logic             commit;
    logic [IDX_W-1:0] run_idx;
    logic             run_sel;
  } ctrl_t;

  // configuration write as seen by the cells
  typedef struct packed {
    logic                 we;
    logic [REG_IDX_W-1:0] idx;
    logic [VAL_W-1:0]     data;
  } cfg_t;

endpackage

FILE: design/edf_tick_if.sv
// input channel of the edf tick scheduler: one tick request with a restart bit
// no dependencies
interface edf_tick_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

FILE: design/edf_result_if.sv
// result channel of the edf tick scheduler: what ran and what missed on one tick
// depends on edf_pkg for field widths
interface edf_result_if
  import edf_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             ran;
  logic [IDX_W-1:0] task_run;
  logic             missed;
  logic [IDX_W-1:0] missed_task;
  logic             faulted;

  modport source (output valid, output ran, output task_run, output missed,
                  output missed_task, output faulted, input ready);
  modport sink (input valid, input ran, input task_run, input missed,
                input missed_task, input faulted, output ready);
endinterface

FILE: design/edf_cell.sv
// one task cell of the edf scheduler chain: config, work and phase of one task
// depends on edf_pkg for link, control and config types
module edf_cell
  import edf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] cell_idx_i,
  input  cfg_t             cfg_i,
  input  link_t            link_i,
  input  ctrl_t            ctrl_i,
  output link_t            link_o
);

  logic [VAL_W-1:0] deadline_q;
  logic [VAL_W-1:0] cost_q;
  logic [VAL_W-1:0] work_q, work_d;
  logic [VAL_W-1:0] phase_q, phase_d;

  logic [VAL_W-1:0] eff_dl;
  logic [VAL_W-1:0] work_eff, phase_eff;
  logic [VAL_W-1:0] work_rel, phase_rel;
  logic [VAL_W-1:0] left;
  logic             boundary;
  logic             my_miss;
  logic             take;
  logic             selected;

  // configuration registers of this task
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadline_q <= VAL_W'(1);
      cost_q     <= '0;
    end else if (cfg_i.we) begin
      if (cfg_i.idx == (REG_DEADLINE_BASE + REG_IDX_W'(cell_idx_i))) begin
        deadline_q <= cfg_i.data;
      end
      if (cfg_i.idx == (REG_COST_BASE + REG_IDX_W'(cell_idx_i))) begin
        cost_q <= cfg_i.data;
      end
    end
  end

  // state as seen after an optional restart
  always_comb begin
    eff_dl    = (deadline_q == '0) ? VAL_W'(1) : deadline_q;
    work_eff  = ctrl_i.start ? cost_q : work_q;
    phase_eff = ctrl_i.start ? '0 : phase_q;
    boundary  = (phase_eff >= eff_dl);
    my_miss   = boundary && (work_eff != '0);
    work_rel  = boundary ? cost_q : work_eff;
    phase_rel = boundary ? '0 : phase_eff;
    left      = eff_dl - phase_rel;
  end

  // miss and minimum search handed to the next cell
  always_comb begin
    take = (work_rel != '0) && (!link_i.found || (left < link_i.best_left));
    link_o.miss      = link_i.miss | my_miss;
    link_o.miss_idx  = link_i.miss ? link_i.miss_idx : cell_idx_i;
    link_o.found     = link_i.found | take;
    link_o.best_idx  = take ? cell_idx_i : link_i.best_idx;
    link_o.best_left = take ? left : link_i.best_left;
  end

  // next work and phase
  always_comb begin
    selected = ctrl_i.run_sel && (ctrl_i.run_idx == cell_idx_i);
    if (ctrl_i.commit) begin
      work_d  = work_rel - VAL_W'(selected);
      phase_d = (phase_rel == VAL_MAX) ? phase_rel : phase_rel + VAL_W'(1);
    end else begin
      work_d  = work_eff;
      phase_d = phase_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q  <= '0;
      phase_q <= '0;
    end else if (ctrl_i.accept) begin
      work_q  <= work_d;
      phase_q <= phase_d;
    end
  end

endmodule

FILE: design/edf_tick_scheduler.sv
// Earliest-deadline-first tick scheduler over TASKS periodic tasks. Every accepted
// tick request yields one result; a tick is taken when the output register is free or
// being read, so the sustained rate is one tick per cycle while results are taken. The
// work of a tick is one pass along a chain of task cells: each cell checks its deadline
// boundary and offers its time to deadline, and the chain carries the first miss and
// the running minimum to the end. Deadlines (cfg indexes 0..3) and costs (4..7) must be
// written only while no tick is pending; the block itself does not enforce this.
// depends on edf_pkg, edf_tick_if, edf_result_if and edf_cell
module edf_tick_scheduler
  import edf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [VAL_W-1:0]     cfg_data_i,
  edf_tick_if.sink             tick_i,
  edf_result_if.source         result_o
);

  logic             run_started_q;
  logic             fault_q, fault_d;
  logic             accept;
  logic             start;
  logic             fault_eff;
  logic             miss_any;
  logic             commit;
  ctrl_t            ctrl;
  cfg_t             cfg;
  link_t            links [TASKS+1];

  logic             out_valid_q;
  logic             ran_q, missed_q, faulted_q;
  logic [IDX_W-1:0] task_run_q, missed_task_q;

  // input handshake: the output register frees as it is taken
  assign tick_i.ready = !out_valid_q || result_o.ready;
  assign accept       = tick_i.valid && tick_i.ready;

  // run control
  always_comb begin
    start     = tick_i.restart || !run_started_q;
    fault_eff = fault_q && !start;
    miss_any  = links[TASKS].miss;
    commit    = accept && !fault_eff && !miss_any;
    fault_d   = fault_eff || miss_any;
    ctrl.accept  = accept;
    ctrl.start   = start;
    ctrl.commit  = commit;
    ctrl.run_sel = links[TASKS].found;
    ctrl.run_idx = links[TASKS].best_idx;
  end

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  assign links[0] = '0;

  // chain of task cells
  for (genvar t = 0; t < TASKS; t++) begin : g_cell
    edf_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(t)),
      .cfg_i      (cfg),
      .link_i     (links[t]),
      .ctrl_i     (ctrl),
      .link_o     (links[t+1])
    );
  end

  // run and fault flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_started_q <= 1'b0;
      fault_q       <= 1'b0;
    end else if (accept) begin
      run_started_q <= 1'b1;
      fault_q       <= fault_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ran_q         <= commit && links[TASKS].found;
      task_run_q    <= (commit && links[TASKS].found) ? links[TASKS].best_idx : '0;
      missed_q      <= !fault_eff && miss_any;
      missed_task_q <= (!fault_eff && miss_any) ? links[TASKS].miss_idx : '0;
      faulted_q     <= fault_d;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.ran         = ran_q;
  assign result_o.task_run    = task_run_q;
  assign result_o.missed      = missed_q;
  assign result_o.missed_task = missed_task_q;
  assign result_o.faulted     = faulted_q;

`ifndef SYNTH
  // a tick that runs a task never reports a fault
  a_ran_not_faulted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.ran |-> !result_o.faulted)
    else $error("task ran on a faulted tick");

  // a miss always leaves the fault flag set
  a_miss_faults: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.missed |-> result_o.faulted && fault_q)
    else $error("miss without fault");

  // a faulted run without restart reports fault and nothing else
  a_fault_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && fault_q && run_started_q && !tick_i.restart |=>
      result_o.valid && result_o.faulted && !result_o.ran && !result_o.missed)
    else $error("faulted run not frozen");
`endif

endmodule

FILE: tb/edf_tick_scheduler_tb.sv
// testbench for edf_tick_scheduler: directed and random tick requests against a local
// earliest-deadline-first predictor, with random idling on both channels
// depends on edf_pkg, edf_tick_if, edf_result_if and the scheduler rtl
module edf_tick_scheduler_tb
  import edf_pkg::*;
;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_TICKS   = 1000;

  // one result as the scheduler reports it
  typedef struct packed {
    logic             ran;
    logic [IDX_W-1:0] task_run;
    logic             missed;
    logic [IDX_W-1:0] missed_task;
    logic             faulted;
  } tick_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic [VAL_W-1:0]     cfg_data;

  edf_tick_if   tick_ch ();
  edf_result_if res_ch ();

  edf_tick_scheduler dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .tick_i     (tick_ch),
    .result_o   (res_ch)
  );

  // predictor copy of the registers and the schedule state
  logic [VAL_W-1:0] deadline_cfg [TASKS];
  logic [VAL_W-1:0] cost_cfg     [TASKS];
  logic [VAL_W-1:0] jobs_left    [TASKS];
  logic [VAL_W-1:0] since_release[TASKS];
  bit               run_live;
  bit               fault_latched;

  tick_result_t expected_results[$];
  int           mismatch_count  = 0;
  int           ticks_sent      = 0;
  int           hold_off_cycles = 0;
  bit           sender_gaps     = 1;
  bit           receiver_stalls = 1;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // a deadline register of zero counts as one
  function automatic int unsigned period_of(input int t);
    return (deadline_cfg[t] == '0) ? 1 : int'(deadline_cfg[t]);
  endfunction

  // advance the predicted schedule by one tick and return what it reports
  function automatic tick_result_t schedule_tick(input bit restart);
    tick_result_t res;
    bit           boundary [TASKS];
    bit           found;
    int unsigned  best;
    int unsigned  best_left;
    int unsigned  left;
    res = '0;
    found = 1'b0;
    best = 0;
    best_left = 0;
    if (restart || !run_live) begin
      for (int t = 0; t < TASKS; t++) begin
        jobs_left[t] = cost_cfg[t];
        since_release[t] = '0;
      end
      fault_latched = 1'b0;
      run_live = 1'b1;
    end
    // frozen after a miss until restart
    if (fault_latched) begin
      res.faulted = 1'b1;
      return res;
    end
    // boundaries, first task with work left at its boundary misses
    for (int t = 0; t < TASKS; t++) begin
      boundary[t] = (since_release[t] >= period_of(t));
      if (boundary[t] && jobs_left[t] != '0 && !res.missed) begin
        res.missed = 1'b1;
        res.missed_task = IDX_W'(t);
      end
    end
    if (res.missed) begin
      fault_latched = 1'b1;
      res.faulted = 1'b1;
      return res;
    end
    // release new jobs
    for (int t = 0; t < TASKS; t++) begin
      if (boundary[t]) begin
        jobs_left[t] = cost_cfg[t];
        since_release[t] = '0;
      end
    end
    // earliest deadline wins, lowest index on ties
    for (int t = 0; t < TASKS; t++) begin
      if (jobs_left[t] != '0) begin
        left = period_of(t) - since_release[t];
        if (!found || left < best_left) begin
          found = 1'b1;
          best = t;
          best_left = left;
        end
      end
    end
    if (found) begin
      jobs_left[best] = jobs_left[best] - 1'b1;
      res.ran = 1'b1;
      res.task_run = IDX_W'(best);
    end
    for (int t = 0; t < TASKS; t++) begin
      if (since_release[t] != VAL_MAX) since_release[t] = since_release[t] + 1'b1;
    end
    return res;
  endfunction

  // one register write, with write enable brought low again after it
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx < REG_COST_BASE) begin
      deadline_cfg[IDX_W'(idx - REG_DEADLINE_BASE)] = val;
    end else begin
      cost_cfg[IDX_W'(idx - REG_COST_BASE)] = val;
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_task(input int t, input int deadline, input int cost);
    write_reg(REG_IDX_W'(REG_DEADLINE_BASE + t), VAL_W'(deadline));
    write_reg(REG_IDX_W'(REG_COST_BASE + t), VAL_W'(cost));
  endtask

  // offer one tick request after a random gap and predict its result on acceptance
  task automatic send_tick(input bit restart);
    int gap;
    gap = sender_gaps ? int'($urandom_range(0, 16)) : 0;
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid   <= 1'b1;
    tick_ch.restart <= restart;
    do @(posedge clk); while (tick_ch.ready !== 1'b1);
    expected_results.push_back(schedule_tick(restart));
    ticks_sent++;
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic wait_drained();
    tick_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // no tasks configured: nothing runs, first tick starts the run implicitly
  task automatic test_idle_defaults();
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  // shortest time to deadline runs first
  task automatic test_edf_order();
    wait_drained();
    set_task(0, 4, 1);
    set_task(1, 6, 2);
    set_task(2, 8, 2);
    set_task(3, 255, 0);
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);
  endtask

  // equal deadlines go to the lowest index
  task automatic test_tie_break();
    wait_drained();
    for (int t = 0; t < TASKS; t++) set_task(t, 5, 1);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
  endtask

  // two tasks miss together, lowest index reported, frozen until restart
  task automatic test_miss_and_restart();
    wait_drained();
    set_task(0, 255, 0);
    set_task(1, 2, 3);
    set_task(2, 2, 3);
    set_task(3, 255, 0);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    send_tick(1'b1);
  endtask

  // zero deadline, deadline lowered under elapsed time, cost changed mid run
  task automatic test_odd_deadlines();
    wait_drained();
    set_task(0, 0, 1);
    set_task(1, 10, 0);
    set_task(2, 255, 0);
    set_task(3, 255, 0);
    send_tick(1'b1);
    repeat (2) send_tick(1'b0);
    wait_drained();
    set_task(1, 2, 2);
    repeat (3) send_tick(1'b0);
  endtask

  // widest deadline and cost next to the tightest task
  task automatic test_extremes();
    wait_drained();
    set_task(0, 255, 255);
    set_task(1, 255, 0);
    set_task(2, 1, 0);
    set_task(3, 1, 1);
    send_tick(1'b1);
    repeat (2) send_tick(1'b0);
  endtask

  // receiver holds off while requests keep coming, then sender waits for the drain
  task automatic test_backpressure();
    wait_drained();
    for (int t = 0; t < TASKS; t++) set_task(t, 8, 2);
    hold_off_cycles = 150;
    sender_gaps = 1'b0;
    send_tick(1'b1);
    repeat (39) send_tick(1'b0);
    wait_drained();
    sender_gaps = 1'b1;
  endtask

  // random phases, mostly feasible task sets, some noise and mid-run changes
  task automatic test_random();
    int  deadline;
    int  cost;
    int  burst;
    bit  well_formed;
    bit  partial;
    bit  restart;
    while (ticks_sent < RANDOM_TICKS) begin
      wait_drained();
      sender_gaps     = ($urandom_range(0, 3) != 0);
      receiver_stalls = ($urandom_range(0, 3) != 0);
      well_formed     = ($urandom_range(0, 3) != 0);
      partial         = ($urandom_range(0, 2) == 0);
      for (int t = 0; t < TASKS; t++) begin
        if (well_formed) begin
          // each task at most a quarter of the time, so a set written in full never misses
          deadline = ($urandom_range(0, 7) == 0) ? 255 : int'($urandom_range(2, 20));
          cost = $urandom_range(0, deadline / 4);
        end else begin
          case ($urandom_range(0, 3))
            0:       deadline = 0;
            1:       deadline = 255;
            default: deadline = $urandom_range(1, 12);
          endcase
          case ($urandom_range(0, 3))
            0:       cost = 0;
            1:       cost = 255;
            2:       cost = $urandom_range(0, 255);
            default: cost = $urandom_range(1, 6);
          endcase
        end
        if (!partial || $urandom_range(0, 1) == 0) set_task(t, deadline, cost);
      end
      burst = $urandom_range(20, 60);
      repeat (burst) begin
        restart = fault_latched ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 49) == 0);
        send_tick(restart);
      end
    end
    sender_gaps = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  // result side: random stalls, long hold-off on request, compare against oldest prediction
  initial begin
    int           pause;
    tick_result_t want;
    tick_result_t got;
    res_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      pause = hold_off_cycles + (receiver_stalls ? int'($urandom_range(0, 16)) : 0);
      hold_off_cycles = 0;
      if (pause > 0) begin
        res_ch.ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
      got = '{res_ch.ran, res_ch.task_run, res_ch.missed, res_ch.missed_task, res_ch.faulted};
      if (expected_results.size() == 0) begin
        $display("%0t: result with no tick request pending, got %p", $time, got);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("ran", want.ran, got.ran);
        check_field("task_run", want.task_run, got.task_run);
        check_field("missed", want.missed, got.missed);
        check_field("missed_task", want.missed_task, got.missed_task);
        check_field("faulted", want.faulted, got.faulted);
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((tick_ch.valid === 1'b1 && tick_ch.ready === 1'b1) ||
          (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // reset, test sequence, final verdict
  initial begin
    rst_n           <= 1'b0;
    tick_ch.valid   <= 1'b0;
    tick_ch.restart <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= '0;
    cfg_data        <= '0;
    for (int t = 0; t < TASKS; t++) begin
      deadline_cfg[t]  = 8'd1;
      cost_cfg[t]      = '0;
      jobs_left[t]     = '0;
      since_release[t] = '0;
    end
    run_live = 1'b0;
    fault_latched = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_defaults();
    test_edf_order();
    test_tie_break();
    test_miss_and_restart();
    test_odd_deadlines();
    test_extremes();
    test_backpressure();
    test_random();

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
design/edf_pkg.sv
design/edf_tick_if.sv
design/edf_result_if.sv
design/edf_cell.sv
design/edf_tick_scheduler.sv
tb/edf_tick_scheduler_tb.sv
